@@ rtl/ppm_pfm_stream_decoder_core_defines.svh @@
// ----------------------------------------------------------------------------
// ppm_pfm_stream_decoder_core_defines
// assertion helpers for the stream decoder
// ----------------------------------------------------------------------------
`ifndef PPM_PFM_STREAM_DECODER_CORE_DEFINES_SVH
`define PPM_PFM_STREAM_DECODER_CORE_DEFINES_SVH

// implication checked on every clock outside reset
`define PPMD_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppmd check failed");

// condition that must never hold outside reset
`define PPMD_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("ppmd check failed");

`endif

@@ rtl/ppmd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppmd_pkg
// shared types and constants of the ppm / pfm stream decoder
// ----------------------------------------------------------------------------
package ppmd_pkg;

   localparam int SIDE_BITS  = 16;
   localparam int TOKEN_BITS = 32;
   localparam int Q_DEPTH    = 4;
   localparam int Q_AW       = $clog2(Q_DEPTH);

   // parse phases
   localparam logic [3:0] PH_MAGIC0 = 4'd0;
   localparam logic [3:0] PH_MAGIC1 = 4'd1;
   localparam logic [3:0] PH_MAGIC2 = 4'd2;
   localparam logic [3:0] PH_WIDTH  = 4'd3;
   localparam logic [3:0] PH_HEIGHT = 4'd4;
   localparam logic [3:0] PH_THIRD  = 4'd5;
   localparam logic [3:0] PH_BIN    = 4'd6;
   localparam logic [3:0] PH_TEXT   = 4'd7;
   localparam logic [3:0] PH_FLOAT  = 4'd8;
   localparam logic [3:0] PH_DONE   = 4'd9;

   // format kinds
   localparam logic [1:0] FK_P3  = 2'd0;
   localparam logic [1:0] FK_P6  = 2'd1;
   localparam logic [1:0] FK_PFC = 2'd2;
   localparam logic [1:0] FK_PFG = 2'd3;

   // sample kinds
   localparam logic [1:0] SK_BYTE  = 2'd0;
   localparam logic [1:0] SK_WORD  = 2'd1;
   localparam logic [1:0] SK_FLOAT = 2'd2;

   // status codes
   localparam logic [2:0] ST_SAMPLE = 3'd0;
   localparam logic [2:0] ST_EMPTY  = 3'd1;
   localparam logic [2:0] ST_MAGIC  = 3'd2;
   localparam logic [2:0] ST_MAXVAL = 3'd3;
   localparam logic [2:0] ST_DATA   = 3'd4;
   localparam logic [2:0] ST_TOKEN  = 3'd5;
   localparam logic [2:0] ST_UNSUP  = 3'd6;

   // one queued result, optionally followed by an out-of-data result
   typedef struct packed {
      logic                  scale;
      logic                  word;
      logic [TOKEN_BITS-1:0] x;
      logic [15:0]           maxv;
      logic [1:0]            ch;
      logic [1:0]            kind;
      logic [2:0]            status;
      logic                  last;
      logic                  err2;
   } job_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   endfunction

endpackage

@@ rtl/ppmd_queue.sv @@
// ----------------------------------------------------------------------------
// ppmd_queue
// small fifo of parsed jobs between the parser and the scaler
// ----------------------------------------------------------------------------
module ppmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ppmd_pkg::job_type push_data,
   input  logic              pop,
   output ppmd_pkg::job_type pop_data,
   output logic              full,
   output logic              empty
);
   import ppmd_pkg::*;

   job_type           mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [Q_AW:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == (Q_AW+1)'(Q_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rptr_ff];

   // pointer and count update
   always_comb begin
      wptr_in = push ? wptr_ff + Q_AW'(1) : wptr_ff;
      rptr_in = pop ? rptr_ff + Q_AW'(1) : rptr_ff;
      cnt_in  = cnt_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/ppmd_parser.sv @@
// ----------------------------------------------------------------------------
// ppmd_parser
// byte-wise header and data parser; emits one job per byte at most
// ----------------------------------------------------------------------------
module ppmd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_take,
   input  logic [7:0]        file_byte,
   input  logic              final_byte,
   input  logic              host_le,
   output logic              job_valid,
   output ppmd_pkg::job_type job
);
   import ppmd_pkg::*;

   logic [3:0]            phase_ff, phase_in;
   logic [1:0]            fmt_ff, fmt_in;
   logic [SIDE_BITS-1:0]  width_ff, width_in, height_ff, height_in;
   logic [15:0]           maxv_ff, maxv_in;
   logic [TOKEN_BITS-1:0] acc_ff, acc_in;
   logic                  started_ff, started_in;
   logic                  file_le_ff, file_le_in;
   logic [2*SIDE_BITS+1:0] left_ff, left_in;
   logic [1:0]            chan_ff, chan_in;
   logic [23:0]           word_ff, word_in;
   logic [1:0]            biw_ff, biw_in;

   // next state and result of one byte
   always_comb begin
      logic                   ws, digit, fin_tok, rv, emit;
      job_type                r;
      logic [TOKEN_BITS-1:0]  v;
      logic [TOKEN_BITS+3:0]  a;
      logic [2*SIDE_BITS-1:0] area;
      logic [31:0]            fw;
      logic [2:0]             fst;
      logic                   do_fail;

      ws       = is_ws(file_byte);
      digit    = (file_byte >= 8'h30) && (file_byte <= 8'h39);
      fin_tok  = 1'b0;
      rv       = 1'b0;
      emit     = 1'b0;
      r        = '0;
      v        = '0;
      a        = '0;
      area     = '0;
      fw       = '0;
      fst      = ST_SAMPLE;
      do_fail  = 1'b0;

      phase_in   = phase_ff;
      fmt_in     = fmt_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      maxv_in    = maxv_ff;
      acc_in     = acc_ff;
      started_in = started_ff;
      file_le_in = file_le_ff;
      left_in    = left_ff;
      chan_in    = chan_ff;
      word_in    = word_ff;
      biw_in     = biw_ff;

      // byte handling
      case (phase_ff)
         PH_MAGIC0: begin
            if (file_byte == "p" || file_byte == "P") phase_in = PH_MAGIC1;
            else begin do_fail = 1'b1; fst = ST_MAGIC; end
         end
         PH_MAGIC1: begin
            phase_in = PH_MAGIC2;
            if (file_byte == "3") fmt_in = FK_P3;
            else if (file_byte == "6") fmt_in = FK_P6;
            else if (file_byte == "F") fmt_in = FK_PFC;
            else if (file_byte == "f") fmt_in = FK_PFG;
            else begin do_fail = 1'b1; fst = ST_MAGIC; end
         end
         PH_MAGIC2: begin
            if (ws) begin
               phase_in   = PH_WIDTH;
               acc_in     = '0;
               started_in = 1'b0;
            end else begin
               do_fail = 1'b1;
               fst     = ST_MAGIC;
            end
         end
         PH_WIDTH, PH_HEIGHT, PH_THIRD: begin
            if (ws) begin
               fin_tok = started_ff;
            end else if (phase_ff == PH_THIRD && fmt_ff[1]) begin
               // scale token flags: neg, nonzero digit, digit, dot
               if (!started_ff && (file_byte == "-" || file_byte == "+")) begin
                  if (file_byte == "-") acc_in[0] = 1'b1;
                  started_in = 1'b1;
               end else if (digit) begin
                  acc_in[2] = 1'b1;
                  if (file_byte != "0") acc_in[1] = 1'b1;
                  started_in = 1'b1;
               end else if (file_byte == "." && !acc_ff[3]) begin
                  acc_in[3]  = 1'b1;
                  started_in = 1'b1;
               end else begin
                  do_fail = 1'b1;
                  fst     = ST_TOKEN;
               end
            end else if (digit) begin
               a = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + (TOKEN_BITS+4)'(file_byte - 8'h30);
               acc_in     = (a[TOKEN_BITS+3:TOKEN_BITS] != '0) ? '1 : a[TOKEN_BITS-1:0];
               started_in = 1'b1;
            end else begin
               do_fail = 1'b1;
               fst     = ST_TOKEN;
            end
         end
         PH_BIN: begin
            emit     = 1'b1;
            r.scale  = 1'b1;
            r.word   = 1'b0;
            r.x      = TOKEN_BITS'(file_byte);
            r.kind   = SK_BYTE;
         end
         PH_TEXT: begin
            if (ws) begin
               fin_tok = started_ff;
            end else if (digit) begin
               a = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + (TOKEN_BITS+4)'(file_byte - 8'h30);
               acc_in     = (a[TOKEN_BITS+3:TOKEN_BITS] != '0) ? '1 : a[TOKEN_BITS-1:0];
               started_in = 1'b1;
            end else begin
               do_fail = 1'b1;
               fst     = ST_TOKEN;
            end
         end
         PH_FLOAT: begin
            if (biw_ff != 2'd3) begin
               word_in[{biw_ff, 3'b000} +: 8] = file_byte;
               biw_in = biw_ff + 2'd1;
            end else begin
               if (file_le_ff == host_le) fw = {file_byte, word_ff};
               else fw = {word_ff[7:0], word_ff[15:8], word_ff[23:16], file_byte};
               word_in = '0;
               biw_in  = '0;
               emit    = 1'b1;
               r.scale = 1'b0;
               r.x     = fw;
               r.kind  = SK_FLOAT;
            end
         end
         default: begin
         end
      endcase

      // a token still open at the final byte is closed by it
      if (final_byte && started_in && !do_fail &&
          (phase_in == PH_WIDTH || phase_in == PH_HEIGHT || phase_in == PH_THIRD ||
           phase_in == PH_TEXT)) begin
         fin_tok = 1'b1;
      end

      // token end: header value or text sample
      if (fin_tok && !do_fail) begin
         v          = acc_in;
         acc_in     = '0;
         started_in = 1'b0;
         if (phase_in == PH_TEXT) begin
            emit    = 1'b1;
            r.scale = 1'b1;
            r.word  = (maxv_ff > 16'd255);
            r.x     = v;
            r.kind  = (maxv_ff > 16'd255) ? SK_WORD : SK_BYTE;
         end else if (phase_in == PH_WIDTH || phase_in == PH_HEIGHT) begin
            if (v[TOKEN_BITS-1:SIDE_BITS] != '0) begin
               do_fail = 1'b1;
               fst     = ST_TOKEN;
            end else if (phase_in == PH_WIDTH) begin
               width_in = v[SIDE_BITS-1:0];
               phase_in = PH_HEIGHT;
            end else begin
               height_in = v[SIDE_BITS-1:0];
               phase_in  = PH_THIRD;
            end
         end else begin
            // third token decides the data phase
            if (fmt_in[1]) begin
               if (!v[2]) begin do_fail = 1'b1; fst = ST_TOKEN; end
               else begin
                  file_le_in = v[0] | ~v[1];
                  phase_in   = PH_FLOAT;
               end
            end else if (v == '0) begin
               do_fail = 1'b1;
               fst     = ST_MAXVAL;
            end else if (fmt_in == FK_P6) begin
               if (v > TOKEN_BITS'(255)) begin do_fail = 1'b1; fst = ST_MAXVAL; end
               else begin maxv_in = v[15:0]; phase_in = PH_BIN; end
            end else begin
               if (v > TOKEN_BITS'(65535)) begin do_fail = 1'b1; fst = ST_UNSUP; end
               else begin maxv_in = v[15:0]; phase_in = PH_TEXT; end
            end
            if (!do_fail) begin
               area    = (2*SIDE_BITS)'(width_in) * (2*SIDE_BITS)'(height_in);
               left_in = (fmt_in == FK_PFG) ? (2*SIDE_BITS+2)'(area)
                         : (2*SIDE_BITS+2)'(area) + {1'b0, area, 1'b0};
               chan_in = '0;
               word_in = '0;
               biw_in  = '0;
               if (left_in == '0) begin
                  do_fail = 1'b1;
                  fst     = ST_EMPTY;
               end
            end
         end
      end

      // sample bookkeeping
      if (emit) begin
         rv       = 1'b1;
         r.ch     = chan_ff;
         r.status = ST_SAMPLE;
         r.maxv   = maxv_in;
         if (left_ff != '0) left_in = left_ff - (2*SIDE_BITS+2)'(1);
         if (fmt_in == FK_PFG || chan_ff == 2'd2) chan_in = 2'd0;
         else chan_in = chan_ff + 2'd1;
         if (left_in == '0) phase_in = PH_DONE;
         r.last = (left_in == '0);
      end

      // error result
      if (do_fail) begin
         rv       = 1'b1;
         r        = '0;
         r.status = fst;
         r.last   = 1'b1;
         phase_in = PH_DONE;
      end

      // end of file: out-of-data check and return to magic
      if (final_byte) begin
         if (phase_in != PH_DONE) begin
            if (rv) r.err2 = 1'b1;
            else begin
               rv       = 1'b1;
               r        = '0;
               r.status = ST_DATA;
               r.last   = 1'b1;
            end
         end
         phase_in   = PH_MAGIC0;
         fmt_in     = '0;
         width_in   = '0;
         height_in  = '0;
         maxv_in    = '0;
         acc_in     = '0;
         started_in = 1'b0;
         file_le_in = 1'b0;
         left_in    = '0;
         chan_in    = '0;
         word_in    = '0;
         biw_in     = '0;
      end

      job_valid = byte_take && rv;
      job       = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC0;
         fmt_ff     <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         maxv_ff    <= '0;
         acc_ff     <= '0;
         started_ff <= 1'b0;
         file_le_ff <= 1'b0;
         left_ff    <= '0;
         chan_ff    <= '0;
         word_ff    <= '0;
         biw_ff     <= '0;
      end else if (byte_take) begin
         phase_ff   <= phase_in;
         fmt_ff     <= fmt_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         maxv_ff    <= maxv_in;
         acc_ff     <= acc_in;
         started_ff <= started_in;
         file_le_ff <= file_le_in;
         left_ff    <= left_in;
         chan_ff    <= chan_in;
         word_ff    <= word_in;
         biw_ff     <= biw_in;
      end
   end

endmodule

@@ rtl/ppmd_scaler.sv @@
// ----------------------------------------------------------------------------
// ppmd_scaler
// back end: pops jobs, scales samples by a bit-serial divider, drives results
// ----------------------------------------------------------------------------
module ppmd_scaler (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  ppmd_pkg::job_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_sample_value,
   output logic [1:0]        rsp_channel_index,
   output logic [1:0]        rsp_sample_kind,
   output logic [2:0]        rsp_status_code,
   output logic              rsp_last_result
);
   import ppmd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_PEND = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   job_type     cur_ff, cur_in;
   logic        ov_ff, ov_in;
   logic [31:0] val_ff, val_in;
   logic [1:0]  ch_ff, ch_in, kind_ff, kind_in;
   logic [2:0]  st_ff, st_in;
   logic        last_ff, last_in;

   logic        out_free;
   logic [16:0] rem_t;
   logic [15:0] top;

   assign out_free  = !ov_ff || rsp_ready;
   assign rem_t     = {rem_ff[15:0], dvd_ff[31]};
   assign top       = q_data.word ? 16'hFFFF : 16'h00FF;

   assign rsp_valid         = ov_ff;
   assign rsp_sample_value  = val_ff;
   assign rsp_channel_index = ch_ff;
   assign rsp_sample_kind   = kind_ff;
   assign rsp_status_code   = st_ff;
   assign rsp_last_result   = last_ff;

   // control and divider step
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      cur_in   = cur_ff;
      ov_in    = ov_ff && !rsp_ready;
      val_in   = val_ff;
      ch_in    = ch_ff;
      kind_in  = kind_ff;
      st_in    = st_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop  = 1'b1;
               cur_in = q_data;
               if (q_data.scale && q_data.x < TOKEN_BITS'(q_data.maxv)) begin
                  // below maxval: quotient fits, divide x*top by maxval
                  dvd_in   = 32'(q_data.x[15:0]) * 32'(top);
                  rem_in   = '0;
                  dsr_in   = q_data.maxv;
                  cnt_in   = '0;
                  state_in = S_DIV;
               end else begin
                  ov_in    = 1'b1;
                  val_in   = q_data.scale ? 32'(top) : q_data.x;
                  ch_in    = q_data.ch;
                  kind_in  = q_data.kind;
                  st_in    = q_data.status;
                  last_in  = q_data.last;
                  state_in = q_data.err2 ? S_PEND : S_IDLE;
               end
            end
         end
         S_DIV: begin
            if (cnt_ff != 5'd31 || out_free) begin
               if (rem_t >= {1'b0, dsr_ff}) begin
                  rem_in = rem_t - {1'b0, dsr_ff};
                  dvd_in = {dvd_ff[30:0], 1'b1};
               end else begin
                  rem_in = rem_t;
                  dvd_in = {dvd_ff[30:0], 1'b0};
               end
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  ov_in    = 1'b1;
                  val_in   = {16'b0, dvd_in[15:0]};
                  ch_in    = cur_ff.ch;
                  kind_in  = cur_ff.kind;
                  st_in    = cur_ff.status;
                  last_in  = cur_ff.last;
                  state_in = cur_ff.err2 ? S_PEND : S_IDLE;
               end
            end
         end
         S_PEND: begin
            if (out_free) begin
               ov_in    = 1'b1;
               val_in   = '0;
               ch_in    = '0;
               kind_in  = '0;
               st_in    = ST_DATA;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cur_ff  <= cur_in;
      val_ff  <= val_in;
      ch_ff   <= ch_in;
      kind_ff <= kind_in;
      st_ff   <= st_in;
      last_ff <= last_in;
   end

endmodule

@@ rtl/ppm_pfm_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// ppm_pfm_stream_decoder_core
// ppm (p3/p6) and pfm (pf/pf gray) byte stream decoder
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one file byte per transfer, req_final_byte on the last one.
//   rsp_* carries one result per transfer: a channel sample or a status.
//   csr_* writes host_little_endian (bit 0 of csr_data); write while idle.
// throughput: the parser takes one byte per cycle while its 4-entry job
//   queue has room. Raw float words and results at or above maxval leave
//   the back end one per cycle while rsp_ready is high; a sample below
//   maxval holds the back end in the bit-serial divider until its quotient
//   is done, so text and p6 data are bound by it. Each job is written into
//   the queue, then popped and registered into the result register.
// reset: synchronous; the parser waits for a magic code, the queue and the
//   output register are empty, host_little_endian is 1.
// stall: when rsp_ready is low the result register holds, the back end
//   stops popping, the queue fills and req_ready drops.
// ----------------------------------------------------------------------------
`include "ppm_pfm_stream_decoder_core_defines.svh"

module ppm_pfm_stream_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_file_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sample_value,
   output logic [1:0]  rsp_channel_index,
   output logic [1:0]  rsp_sample_kind,
   output logic [2:0]  rsp_status_code,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import ppmd_pkg::*;

   logic    host_le_ff, host_le_in;
   logic    byte_take, job_valid, q_full, q_empty, q_pop;
   job_type job, q_data;

   assign req_ready = !q_full;
   assign byte_take = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // host byte order register
   assign host_le_in = (csr_valid && csr_ready) ? csr_data : host_le_ff;
   always_ff @(posedge clock) begin
      if (reset) host_le_ff <= 1'b1;
      else host_le_ff <= host_le_in;
   end

   ppmd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (byte_take),
      .file_byte  (req_file_byte),
      .final_byte (req_final_byte),
      .host_le    (host_le_ff),
      .job_valid  (job_valid),
      .job        (job)
   );

   ppmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_data (job),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   ppmd_scaler u_scaler (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_data            (q_data),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_channel_index (rsp_channel_index),
      .rsp_sample_kind   (rsp_sample_kind),
      .rsp_status_code   (rsp_status_code),
      .rsp_last_result   (rsp_last_result)
   );

   // checks
   `PPMD_ASSERT_NEVER(a_no_push_full, job_valid && q_full)
   `PPMD_ASSERT_NEVER(a_no_pop_empty, q_pop && q_empty)
   `PPMD_ASSERT_IMPLY(a_status_clean, rsp_valid && (rsp_status_code != ST_SAMPLE), rsp_last_result && (rsp_sample_value == '0) && (rsp_channel_index == '0))

endmodule
